### hw/rtl/drmc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drmc_pkg
// shared types, codes and register map of the rack motor / dryer controller
// ---------------------------------------------------------------------------
package drmc_pkg;

  // system modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_DRYING = 3'd1,
    MODE_MOVING = 3'd2,
    MODE_PAUSED = 3'd3,
    MODE_DRYER  = 3'd4
  } mode_t;

  // motor drive
  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_BWD  = 2'd2
  } drive_t;

  // button presses handed to the key unit
  typedef enum logic [2:0] {
    BTN_NONE  = 3'd0,
    BTN_MOTOR = 3'd1,
    BTN_DRYER = 3'd2,
    BTN_INC   = 3'd3,
    BTN_DEC   = 3'd4
  } btn_t;

  // func codes of an input word
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_MOTOR = 2'd1;
  localparam logic [1:0] FUNC_DRYER = 2'd2;

  // key codes (keypad and remote)
  localparam logic [2:0] KEY_MOTOR = 3'd1;
  localparam logic [2:0] KEY_DRYER = 3'd2;
  localparam logic [2:0] KEY_INC   = 3'd3;
  localparam logic [2:0] KEY_DEC   = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_LUX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_MS   = 3'd5;

  // configuration reset values
  localparam logic [15:0] RST_NIGHT_LUX   = 16'd5;
  localparam logic [7:0]  RST_DEFAULT_MIN = 8'd30;
  localparam logic [7:0]  RST_MAX_MIN     = 8'd120;
  localparam logic [7:0]  RST_MIN_MIN     = 8'd5;
  localparam logic [5:0]  RST_STEP_MIN    = 6'd5;
  localparam logic [19:0] RST_MINUTE_MS   = 20'd60000;

  typedef struct packed {
    logic [15:0] night_lux;
    logic [7:0]  default_min;
    logic [7:0]  max_min;
    logic [7:0]  min_min;
    logic [5:0]  step_min;
    logic [19:0] minute_ms;
  } cfg_t;

  // controller state
  typedef struct packed {
    mode_t       mode;
    drive_t      drv;
    logic        heater;
    logic        motor_tog;
    logic        heater_tog;
    logic [7:0]  minutes;
    logic [31:0] acc_ms;
  } st_t;

  // one input word
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] light_level;
    logic        raining;
    logic [2:0]  keypad_key;
    logic [2:0]  remote_key;
    logic        limit_one;
    logic        limit_two;
    logic [15:0] elapsed_ms;
  } item_t;

  // dryer stop: back to idle, timer restored
  function automatic st_t heater_shutdown(st_t s, logic [7:0] default_min);
    st_t r;
    r            = s;
    r.mode       = MODE_IDLE;
    r.heater     = 1'b0;
    r.heater_tog = 1'b1;
    r.minutes    = default_min;
    r.acc_ms     = '0;
    return r;
  endfunction

endpackage

### hw/rtl/drmc_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drmc_cfg
// configuration register file, written through the cfg channel
// ---------------------------------------------------------------------------
module drmc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [drmc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [drmc_pkg::CFG_DAT_W-1:0]  wr_data,
  output drmc_pkg::cfg_t                  cfg_o
);
  import drmc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.night_lux   <= RST_NIGHT_LUX;
      cfg_r.default_min <= RST_DEFAULT_MIN;
      cfg_r.max_min     <= RST_MAX_MIN;
      cfg_r.min_min     <= RST_MIN_MIN;
      cfg_r.step_min    <= RST_STEP_MIN;
      cfg_r.minute_ms   <= RST_MINUTE_MS;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_NIGHT_LUX:   cfg_r.night_lux   <= wr_data[15:0];
        CFG_DEFAULT_MIN: cfg_r.default_min <= wr_data[7:0];
        CFG_MAX_MIN:     cfg_r.max_min     <= wr_data[7:0];
        CFG_MIN_MIN:     cfg_r.min_min     <= wr_data[7:0];
        CFG_STEP_MIN:    cfg_r.step_min    <= wr_data[5:0];
        CFG_MINUTE_MS:   cfg_r.minute_ms   <= wr_data[19:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

### hw/rtl/drmc_key.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drmc_key
// applies one button press (motor, dryer, increase, decrease) to the state
// ---------------------------------------------------------------------------
module drmc_key (
  input  drmc_pkg::st_t  st_i,
  input  drmc_pkg::cfg_t cfg_i,
  input  drmc_pkg::btn_t btn_i,
  input  logic           rain_i,
  output drmc_pkg::st_t  st_o
);
  import drmc_pkg::*;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_PAUSE, ACT_DRY, ACT_COLLECT, ACT_INC, ACT_DEC, ACT_START, ACT_STOP
  } act_t;

  always_comb begin
    st_t         s;
    act_t        act;
    logic [8:0]  sum;
    logic [8:0]  floor_sum;
    s         = st_i;
    act       = ACT_NONE;
    sum       = {1'b0, st_i.minutes} + {3'b0, cfg_i.step_min};
    floor_sum = {1'b0, cfg_i.min_min} + {3'b0, cfg_i.step_min};

    // button decode, toggles flip here
    unique case (btn_i)
      BTN_MOTOR: begin
        unique case (st_i.mode)
          MODE_DRYING: begin
            s.motor_tog = 1'b0;
            act         = ACT_COLLECT;
          end
          MODE_IDLE: begin
            s.motor_tog = 1'b1;
            act         = ACT_DRY;
          end
          MODE_MOVING: act = ACT_PAUSE;
          MODE_PAUSED: begin
            s.motor_tog = ~st_i.motor_tog;
            act         = st_i.motor_tog ? ACT_COLLECT : ACT_DRY;
          end
          default: act = ACT_NONE;
        endcase
      end
      BTN_DRYER: begin
        if (st_i.heater_tog) begin
          if (st_i.mode == MODE_IDLE) begin
            s.heater_tog = 1'b0;
            act          = ACT_START;
          end
        end else begin
          s.heater_tog = 1'b1;
          act          = ACT_STOP;
        end
      end
      BTN_INC: act = ACT_INC;
      BTN_DEC: act = ACT_DEC;
      default: act = ACT_NONE;
    endcase

    // action
    unique case (act)
      ACT_PAUSE: begin
        if (s.mode == MODE_MOVING) begin
          s.drv  = DRV_STOP;
          s.mode = MODE_PAUSED;
        end
      end
      ACT_DRY: begin
        if (s.mode == MODE_DRYER) s = heater_shutdown(s, cfg_i.default_min);
        if (!rain_i) begin
          s.drv  = DRV_FWD;
          s.mode = MODE_MOVING;
        end
      end
      ACT_COLLECT: begin
        s.drv  = DRV_BWD;
        s.mode = MODE_MOVING;
      end
      ACT_INC: begin
        if (sum > {1'b0, cfg_i.max_min}) s.minutes = cfg_i.max_min;
        else                             s.minutes = sum[7:0];
      end
      ACT_DEC: begin
        // minutes - step < min, done without going negative
        if ({1'b0, s.minutes} < floor_sum) s.minutes = cfg_i.min_min;
        else s.minutes = s.minutes - {2'b0, cfg_i.step_min};
      end
      ACT_START: begin
        if (s.mode == MODE_IDLE) begin
          s.mode   = MODE_DRYER;
          s.heater = 1'b1;
        end
      end
      ACT_STOP: s = heater_shutdown(s, cfg_i.default_min);
      default: ;
    endcase

    st_o = s;
  end

endmodule

### hw/rtl/drmc_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drmc_step
// next-state logic for one word: auto retract, keys, limits, countdown
// ---------------------------------------------------------------------------
module drmc_step (
  input  drmc_pkg::st_t   st_i,
  input  drmc_pkg::cfg_t  cfg_i,
  input  drmc_pkg::item_t item_i,
  output drmc_pkg::st_t   st_o
);
  import drmc_pkg::*;

  function automatic btn_t key_to_btn(logic [2:0] key);
    btn_t b;
    case (key)
      KEY_MOTOR: b = BTN_MOTOR;
      KEY_DRYER: b = BTN_DRYER;
      KEY_INC:   b = BTN_INC;
      KEY_DEC:   b = BTN_DEC;
      default:   b = BTN_NONE;
    endcase
    return b;
  endfunction

  logic tick;
  st_t  st_auto, st_k1, st_k2;
  btn_t btn1, btn2;

  assign tick = (item_i.func == FUNC_TICK);

  // night or rain retraction
  always_comb begin
    st_auto = st_i;
    if (tick) begin
      if (item_i.light_level < cfg_i.night_lux) begin
        if (st_i.mode == MODE_DRYING) begin
          st_auto.drv  = DRV_BWD;
          st_auto.mode = MODE_MOVING;
        end
      end else if (item_i.raining &&
                   (st_i.mode == MODE_DRYING || st_i.mode == MODE_PAUSED)) begin
        st_auto.drv  = DRV_BWD;
        st_auto.mode = MODE_MOVING;
      end
    end
  end

  // first press: remote bus button, else keypad
  always_comb begin
    case (item_i.func)
      FUNC_TICK:  btn1 = key_to_btn(item_i.keypad_key);
      FUNC_MOTOR: btn1 = BTN_MOTOR;
      FUNC_DRYER: btn1 = BTN_DRYER;
      default:    btn1 = BTN_NONE;
    endcase
    btn2 = tick ? key_to_btn(item_i.remote_key) : BTN_NONE;
  end

  drmc_key u_key1 (
    .st_i   (st_auto),
    .cfg_i  (cfg_i),
    .btn_i  (btn1),
    .rain_i (item_i.raining),
    .st_o   (st_k1)
  );

  drmc_key u_key2 (
    .st_i   (st_k1),
    .cfg_i  (cfg_i),
    .btn_i  (btn2),
    .rain_i (item_i.raining),
    .st_o   (st_k2)
  );

  // limit switches, then dryer countdown
  always_comb begin
    st_t         s;
    logic [31:0] acc;
    s   = st_k2;
    acc = st_k2.acc_ms + {16'b0, item_i.elapsed_ms};
    if (tick) begin
      if (s.mode == MODE_MOVING && s.drv != DRV_STOP &&
          item_i.limit_one != item_i.limit_two) begin
        if (item_i.limit_one && s.drv == DRV_BWD) begin
          s.drv  = DRV_STOP;
          s.mode = MODE_IDLE;
        end else if (item_i.limit_two && s.drv == DRV_FWD) begin
          s.drv  = DRV_STOP;
          s.mode = MODE_DRYING;
        end
      end
      if (s.mode == MODE_DRYER) begin
        s.acc_ms = acc;
        if (acc >= {12'b0, cfg_i.minute_ms}) begin
          s.acc_ms = '0;
          if (s.minutes != 8'd0) s.minutes = s.minutes - 8'd1;
          if (s.minutes == 8'd0) s = heater_shutdown(s, cfg_i.default_min);
        end
      end
    end
    st_o = s;
  end

endmodule

### hw/rtl/drying_rack_motor_dryer_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drying_rack_motor_dryer_controller
// clothes rack motor and heater controller, one result word per input word
// ---------------------------------------------------------------------------
// path: a word is taken into the input register, then its result word is written
//   into the state register that doubles as result register
// throughput: one word per cycle while result words are taken, set by the
//   combinational next-state logic
// reset (synchronous, rst_n low): state idle, drive stopped, heater off,
//   timer 30 minutes, config registers at their defaults, both stages empty
module drying_rack_motor_dryer_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [15:0]                     in_light_level,
  input  logic                            in_raining,
  input  logic [2:0]                      in_keypad_key,
  input  logic [2:0]                      in_remote_key,
  input  logic                            in_limit_one,
  input  logic                            in_limit_two,
  input  logic [15:0]                     in_elapsed_ms,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_system_mode,
  output logic [1:0]                      out_motor_drive,
  output logic                            out_heater_on,
  output logic [7:0]                      out_minutes_left,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drmc_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import drmc_pkg::*;

  cfg_t  cfg;
  item_t item_r;
  logic  item_vld_r;
  logic  out_vld_r;
  st_t   st_r, st_nxt;
  logic  advance;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  drmc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_o    (cfg)
  );

  // the state register is also the result register: it moves only when
  // the held word is taken or the result slot is empty
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !item_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.func        <= in_func;
      item_r.light_level <= in_light_level;
      item_r.raining     <= in_raining;
      item_r.keypad_key  <= in_keypad_key;
      item_r.remote_key  <= in_remote_key;
      item_r.limit_one   <= in_limit_one;
      item_r.limit_two   <= in_limit_two;
      item_r.elapsed_ms  <= in_elapsed_ms;
    end
  end

  // whole per-word update in one pass
  drmc_step u_step (
    .st_i   (st_r),
    .cfg_i  (cfg),
    .item_i (item_r),
    .st_o   (st_nxt)
  );

  // controller state / result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode       <= MODE_IDLE;
      st_r.drv        <= DRV_STOP;
      st_r.heater     <= 1'b0;
      st_r.motor_tog  <= 1'b0;
      st_r.heater_tog <= 1'b1;
      st_r.minutes    <= RST_DEFAULT_MIN;
      st_r.acc_ms     <= '0;
      out_vld_r       <= 1'b0;
    end else if (advance) begin
      if (item_vld_r) st_r <= st_nxt;
      out_vld_r <= item_vld_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_system_mode  = st_r.mode;
  assign out_motor_drive  = st_r.drv;
  assign out_heater_on    = st_r.heater;
  assign out_minutes_left = st_r.minutes;

  // heater follows dryer mode exactly
  a_heater_mode: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.heater == (st_r.mode == MODE_DRYER))
    else $error("heater level out of step with dryer mode");

  // moving always has a drive direction
  a_moving_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == MODE_MOVING) |-> (st_r.drv != DRV_STOP))
    else $error("moving mode with motor stopped");

  // accumulator only runs while the dryer is on
  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode != MODE_DRYER) |-> (st_r.acc_ms == 32'd0))
    else $error("millisecond accumulator nonzero outside dryer mode");

  // a stalled result word keeps the state frozen
  a_stall_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> $stable(st_r))
    else $error("state changed while result word stalled");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench for drying_rack_motor_dryer_controller
// drives input words and configuration writes, follows every word with its
// own model of the rack/heater state and checks each result word in order
// ---------------------------------------------------------------------------
module testbench;
  import drmc_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int WORDS_PER_PHASE = 290;
  localparam int LONG_STALL      = 400;

  // input codes the package does not name
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam logic [2:0] KEY_NONE      = 3'd0;
  localparam logic [2:0] KEY_BAD_FIRST = 3'd5;
  localparam logic [2:0] KEY_BAD_MID   = 3'd6;
  localparam logic [2:0] KEY_BAD_LAST  = 3'd7;

  // what one button press turns into before it is carried out
  typedef enum int {
    DO_NOTHING, DO_PAUSE, DO_EXTEND, DO_RETRACT,
    DO_LONGER, DO_SHORTER, DO_HEAT, DO_COOL
  } rack_cmd_t;

  // one result word as the block should present it
  typedef struct packed {
    mode_t      mode;
    drive_t     drv;
    logic       heater;
    logic [7:0] minutes;
  } status_t;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_func          = '0;
  logic [15:0]          in_light_level   = '0;
  logic                 in_raining       = 1'b0;
  logic [2:0]           in_keypad_key    = '0;
  logic [2:0]           in_remote_key    = '0;
  logic                 in_limit_one     = 1'b0;
  logic                 in_limit_two     = 1'b0;
  logic [15:0]          in_elapsed_ms    = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic [2:0]           out_system_mode;
  logic [1:0]           out_motor_drive;
  logic                 out_heater_on;
  logic [7:0]           out_minutes_left;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [CFG_DAT_W-1:0] cfg_data         = '0;

  // shadow copy of the controller: registers and state
  cfg_t        shadow_cfg;
  mode_t       cur_mode;
  drive_t      cur_drive;
  logic        heat;
  logic        motor_flip;
  logic        heat_flip;
  logic [7:0]  mins_left;
  logic [31:0] ms_acc;

  // words waiting to be offered, and result words still owed by the block
  drmc_pkg::item_t pending_words[$];
  status_t         expected_outputs[$];
  drmc_pkg::item_t offered_word;
  logic            word_in_flight = 1'b0;

  // idle rates in percent, set per phase; a long receiver hold on request
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_request  = 0;
  int stall_left     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  drying_rack_motor_dryer_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_light_level   (in_light_level),
    .in_raining       (in_raining),
    .in_keypad_key    (in_keypad_key),
    .in_remote_key    (in_remote_key),
    .in_limit_one     (in_limit_one),
    .in_limit_two     (in_limit_two),
    .in_elapsed_ms    (in_elapsed_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_system_mode  (out_system_mode),
    .out_motor_drive  (out_motor_drive),
    .out_heater_on    (out_heater_on),
    .out_minutes_left (out_minutes_left),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // ---- rack / heater model ------------------------------------------------

  // heater off: back to idle, timer reloaded, minute accumulator cleared
  function automatic void heater_off_reset();
    cur_mode  = MODE_IDLE;
    heat      = 1'b0;
    heat_flip = 1'b1;
    mins_left = shadow_cfg.default_min;
    ms_acc    = '0;
  endfunction

  function automatic void start_motor(drive_t d);
    cur_drive = d;
    cur_mode  = MODE_MOVING;
  endfunction

  function automatic void stop_motor(mode_t m);
    cur_drive = DRV_STOP;
    cur_mode  = m;
  endfunction

  // motor button: direction alternates only out of the paused state
  function automatic rack_cmd_t motor_press();
    rack_cmd_t c;
    c = DO_NOTHING;
    case (cur_mode)
      MODE_DRYING: begin
        motor_flip = 1'b0;
        c = DO_RETRACT;
      end
      MODE_IDLE: begin
        motor_flip = 1'b1;
        c = DO_EXTEND;
      end
      MODE_MOVING: c = DO_PAUSE;
      MODE_PAUSED: begin
        motor_flip = ~motor_flip;
        c = motor_flip ? DO_EXTEND : DO_RETRACT;
      end
      default: c = DO_NOTHING;
    endcase
    return c;
  endfunction

  // dryer button: a start is refused (and the toggle restored) unless idle
  function automatic rack_cmd_t dryer_press();
    rack_cmd_t c;
    heat_flip = ~heat_flip;
    if (!heat_flip) begin
      if (cur_mode != MODE_IDLE) begin
        heat_flip = 1'b1;
        c = DO_NOTHING;
      end else begin
        c = DO_HEAT;
      end
    end else begin
      c = DO_COOL;
    end
    return c;
  endfunction

  function automatic void apply_action(rack_cmd_t c, logic rain);
    int sum;
    int bound;
    case (c)
      DO_PAUSE: if (cur_mode == MODE_MOVING) stop_motor(MODE_PAUSED);
      DO_EXTEND: begin
        if (cur_mode == MODE_DRYER) heater_off_reset();
        // never drive out into rain
        if (!rain) start_motor(DRV_FWD);
      end
      DO_RETRACT: start_motor(DRV_BWD);
      DO_LONGER: begin
        sum   = int'(mins_left) + int'(shadow_cfg.step_min);
        bound = int'(shadow_cfg.max_min);
        if (sum > bound) sum = bound;
        mins_left = sum[7:0];
      end
      DO_SHORTER: begin
        // signed difference, clamped before any wrap can happen
        sum   = int'(mins_left) - int'(shadow_cfg.step_min);
        bound = int'(shadow_cfg.min_min);
        if (sum < bound) sum = bound;
        mins_left = sum[7:0];
      end
      DO_HEAT: if (cur_mode == MODE_IDLE) begin
        cur_mode = MODE_DRYER;
        heat     = 1'b1;
      end
      DO_COOL: heater_off_reset();
      default: ;
    endcase
  endfunction

  function automatic void key_action(logic [2:0] key, logic rain);
    rack_cmd_t c;
    case (key)
      KEY_MOTOR: c = motor_press();
      KEY_DRYER: c = dryer_press();
      KEY_INC:   c = DO_LONGER;
      KEY_DEC:   c = DO_SHORTER;
      default:   c = DO_NOTHING;
    endcase
    apply_action(c, rain);
  endfunction

  // one input word through the controller; returns the status it leaves
  function automatic status_t advance_controller(drmc_pkg::item_t w);
    status_t s;
    case (w.func)
      FUNC_MOTOR: apply_action(motor_press(), w.raining);
      FUNC_DRYER: apply_action(dryer_press(), w.raining);
      FUNC_TICK: begin
        // night pulls the rack in from drying; rain also from paused
        if (w.light_level < shadow_cfg.night_lux) begin
          if (cur_mode == MODE_DRYING) start_motor(DRV_BWD);
        end else if (w.raining && (cur_mode == MODE_DRYING || cur_mode == MODE_PAUSED)) begin
          start_motor(DRV_BWD);
        end
        key_action(w.keypad_key, w.raining);
        key_action(w.remote_key, w.raining);
        // limit switches count only when exactly one of them is closed
        if (cur_mode == MODE_MOVING && cur_drive != DRV_STOP &&
            w.limit_one != w.limit_two) begin
          if (w.limit_one && cur_drive == DRV_BWD) stop_motor(MODE_IDLE);
          else if (w.limit_two && cur_drive == DRV_FWD) stop_motor(MODE_DRYING);
        end
        // minute countdown; a timer already at zero stays there and ends the run
        if (cur_mode == MODE_DRYER) begin
          ms_acc = ms_acc + 32'(w.elapsed_ms);
          if (ms_acc >= 32'(shadow_cfg.minute_ms)) begin
            ms_acc = '0;
            if (mins_left != 8'd0) mins_left = mins_left - 8'd1;
            if (mins_left == 8'd0) heater_off_reset();
          end
        end
      end
      default: ;
    endcase
    s.mode    = cur_mode;
    s.drv     = cur_drive;
    s.heater  = heat;
    s.minutes = mins_left;
    return s;
  endfunction

  // ---- stimulus helpers ---------------------------------------------------

  function automatic drmc_pkg::item_t word_of(logic [1:0] f, logic [15:0] lux, logic rain,
                                              logic [2:0] kk, logic [2:0] rk,
                                              logic l1, logic l2, logic [15:0] ms);
    drmc_pkg::item_t w;
    w = '{f, lux, rain, kk, rk, l1, l2, ms};
    return w;
  endfunction

  function automatic logic [2:0] random_key(int none_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < none_pct) return KEY_NONE;
    pick = $urandom_range(99);
    if (pick < 25) return KEY_MOTOR;
    if (pick < 50) return KEY_DRYER;
    if (pick < 70) return KEY_INC;
    if (pick < 90) return KEY_DEC;
    return 3'($urandom_range(KEY_BAD_FIRST, KEY_BAD_LAST));
  endfunction

  // mostly ticks with real keys and limit hits, so the rack cycles through
  // extend, dry, retract, pause and heater runs; a few odd codes mixed in
  function automatic drmc_pkg::item_t random_word();
    drmc_pkg::item_t w;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)      w.func = FUNC_TICK;
    else if (pick < 82) w.func = FUNC_MOTOR;
    else if (pick < 94) w.func = FUNC_DRYER;
    else                w.func = FUNC_UNUSED;
    pick = $urandom_range(99);
    if (pick < 15)      w.light_level = 16'($urandom_range(0, 40));
    else if (pick < 25) w.light_level = shadow_cfg.night_lux + 16'($urandom_range(0, 2)) - 16'd1;
    else                w.light_level = 16'($urandom);
    w.raining    = ($urandom_range(99) < 15);
    w.keypad_key = random_key(45);
    w.remote_key = random_key(80);
    pick = $urandom_range(99);
    w.limit_one = (pick >= 55 && pick < 75) || pick >= 95;
    w.limit_two = (pick >= 75);
    pick = $urandom_range(99);
    if (pick < 15)      w.elapsed_ms = '0;
    else if (pick < 35) w.elapsed_ms = 16'($urandom_range(0, 255));
    else if (pick < 90) w.elapsed_ms = 16'($urandom);
    else                w.elapsed_ms = 16'hFFFF - 16'($urandom_range(0, 3));
    return w;
  endfunction

  // hold cfg_valid until the write is taken; caller drops it after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NIGHT_LUX:   shadow_cfg.night_lux   = val[15:0];
      CFG_DEFAULT_MIN: shadow_cfg.default_min = val[7:0];
      CFG_MAX_MIN:     shadow_cfg.max_min     = val[7:0];
      CFG_MIN_MIN:     shadow_cfg.min_min     = val[7:0];
      CFG_STEP_MIN:    shadow_cfg.step_min    = val[5:0];
      CFG_MINUTE_MS:   shadow_cfg.minute_ms   = val;
      default: ;
    endcase
  endtask

  task automatic load_setting(input cfg_t s);
    write_reg(CFG_NIGHT_LUX,   CFG_DAT_W'(s.night_lux));
    write_reg(CFG_DEFAULT_MIN, CFG_DAT_W'(s.default_min));
    write_reg(CFG_MAX_MIN,     CFG_DAT_W'(s.max_min));
    write_reg(CFG_MIN_MIN,     CFG_DAT_W'(s.min_min));
    write_reg(CFG_STEP_MIN,    CFG_DAT_W'(s.step_min));
    write_reg(CFG_MINUTE_MS,   s.minute_ms);
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued word is taken and every result word is back
  task automatic drain();
    while (pending_words.size() != 0 || word_in_flight || expected_outputs.size() != 0)
      @(posedge clk);
    // spare clock edges before touching the registers
    repeat (4) @(posedge clk);
  endtask

  // ---- driver: offers queued words, predicts at each accepted word --------
  always @(posedge clk) begin : source
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_outputs.push_back(advance_controller(offered_word));
        word_in_flight = 1'b0;
      end
      // a new word may go out only when none is waiting to be taken
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_word   = pending_words.pop_front();
          word_in_flight = 1'b1;
          in_func        <= offered_word.func;
          in_light_level <= offered_word.light_level;
          in_raining     <= offered_word.raining;
          in_keypad_key  <= offered_word.keypad_key;
          in_remote_key  <= offered_word.remote_key;
          in_limit_one   <= offered_word.limit_one;
          in_limit_two   <= offered_word.limit_two;
          in_elapsed_ms  <= offered_word.elapsed_ms;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor: checks result words in order, drives out_ready ------------
  always @(posedge clk) begin : sink
    status_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $error("result word with nothing expected: mode %0d drive %0d heater %0d minutes %0d",
                 out_system_mode, out_motor_drive, out_heater_on, out_minutes_left);
          mismatch_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (out_system_mode !== want.mode) begin
            $error("system_mode: expected %0d, got %0d", want.mode, out_system_mode);
            mismatch_count++;
          end
          if (out_motor_drive !== want.drv) begin
            $error("motor_drive: expected %0d, got %0d", want.drv, out_motor_drive);
            mismatch_count++;
          end
          if (out_heater_on !== want.heater) begin
            $error("heater_on: expected %0d, got %0d", want.heater, out_heater_on);
            mismatch_count++;
          end
          if (out_minutes_left !== want.minutes) begin
            $error("minutes_left: expected %0d, got %0d", want.minutes, out_minutes_left);
            mismatch_count++;
          end
        end
      end
      // a requested long hold overrides the random back-pressure
      if (stall_request > 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---- watchdog -----------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** drying_rack_motor_dryer_controller: FAILED **");
      $finish;
    end
  end

  // ---- sequence of phases -------------------------------------------------
  initial begin
    cfg_t plan [6];

    shadow_cfg = '{night_lux: RST_NIGHT_LUX, default_min: RST_DEFAULT_MIN,
                   max_min: RST_MAX_MIN, min_min: RST_MIN_MIN,
                   step_min: RST_STEP_MIN, minute_ms: RST_MINUTE_MS};
    cur_mode   = MODE_IDLE;
    cur_drive  = DRV_STOP;
    heat       = 1'b0;
    motor_flip = 1'b0;
    heat_flip  = 1'b1;
    mins_left  = 8'd30;
    ms_acc     = '0;

    // all lows, all highs (past the nominal ranges where the fields allow),
    // a typical one, zero-length minutes with zero floor and zero reload,
    // a floor above the ceiling, and the reset values
    plan[0] = '{night_lux: 16'd0, default_min: 8'd1, max_min: 8'd1, min_min: 8'd1,
                step_min: 6'd1, minute_ms: 20'd1};
    plan[1] = '{night_lux: 16'hFFFF, default_min: 8'd255, max_min: 8'd255, min_min: 8'd255,
                step_min: 6'd63, minute_ms: 20'hFFFFF};
    plan[2] = '{night_lux: 16'd1000, default_min: 8'd30, max_min: 8'd120, min_min: 8'd5,
                step_min: 6'd5, minute_ms: 20'd20000};
    plan[3] = '{night_lux: 16'd200, default_min: 8'd0, max_min: 8'd40, min_min: 8'd0,
                step_min: 6'd60, minute_ms: 20'd0};
    plan[4] = '{night_lux: 16'd300, default_min: 8'd200, max_min: 8'd50, min_min: 8'd100,
                step_min: 6'd7, minute_ms: 20'd100};
    plan[5] = '{night_lux: RST_NIGHT_LUX, default_min: RST_DEFAULT_MIN,
                max_min: RST_MAX_MIN, min_min: RST_MIN_MIN,
                step_min: RST_STEP_MIN, minute_ms: RST_MINUTE_MS};

    send_idle_pct = 24;
    recv_idle_pct = 70;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk with the reset register values
    // unused func with every field bit set, then unused key codes
    pending_words.push_back(word_of(FUNC_UNUSED, 16'hFFFF, 1'b1, KEY_BAD_LAST, KEY_BAD_LAST,
                                    1'b1, 1'b1, 16'hFFFF));
    pending_words.push_back(word_of(FUNC_TICK, 16'hFFFF, 1'b0, KEY_BAD_FIRST, KEY_BAD_MID,
                                    1'b0, 1'b0, 16'd0));
    // extend, hit the outer switch, night pulls it back in
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_MOTOR, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_NONE, KEY_NONE,
                                    1'b0, 1'b1, 16'd0));
    pending_words.push_back(word_of(FUNC_TICK, 16'd0, 1'b0, KEY_NONE, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    // both switches closed: ignored
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_NONE, KEY_NONE,
                                    1'b1, 1'b1, 16'd0));
    // remote key pauses, rain retracts from paused, inner switch stops
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_NONE, KEY_MOTOR,
                                    1'b0, 1'b0, 16'd0));
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b1, KEY_NONE, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_NONE, KEY_NONE,
                                    1'b1, 1'b0, 16'd0));
    // remote motor button refuses to extend in rain
    pending_words.push_back(word_of(FUNC_MOTOR, 16'd0, 1'b1, KEY_NONE, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    // remote dryer starts heater; motor button does nothing while heating
    pending_words.push_back(word_of(FUNC_DRYER, 16'd0, 1'b0, KEY_NONE, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    pending_words.push_back(word_of(FUNC_MOTOR, 16'd0, 1'b0, KEY_NONE, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    // two increases, then a decrease with a full minute elapsed
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_INC, KEY_INC,
                                    1'b0, 1'b0, 16'd0));
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_DEC, KEY_NONE,
                                    1'b0, 1'b0, 16'hFFFF));
    // remote dryer key stops heater
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_MOTOR, KEY_DRYER,
                                    1'b0, 1'b0, 16'd0));
    // dryer button while the motor runs is refused
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_MOTOR, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    pending_words.push_back(word_of(FUNC_DRYER, 16'd100, 1'b0, KEY_NONE, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_NONE, KEY_NONE,
                                    1'b0, 1'b1, 16'd0));
    // rain retracts, same tick's motor key pauses it
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b1, KEY_MOTOR, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    pending_words.push_back(word_of(FUNC_TICK, 16'd0, 1'b0, KEY_DEC, KEY_DEC,
                                    1'b0, 1'b0, 16'd0));
    drain();

    // zero floor, big step, zero-length minute
    write_reg(CFG_MIN_MIN, 20'd0);
    write_reg(CFG_STEP_MIN, 20'd63);
    write_reg(CFG_MINUTE_MS, 20'd0);
    cfg_valid <= 1'b0;
    // paused toggles to retract and stops on the inner switch in one tick
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_MOTOR, KEY_NONE,
                                    1'b1, 1'b0, 16'd0));
    pending_words.push_back(word_of(FUNC_DRYER, 16'd100, 1'b0, KEY_NONE, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    // decrease clamps at zero, then a zero-length minute ends the heater run
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_DEC, KEY_NONE,
                                    1'b0, 1'b0, 16'd0));
    // two increases saturate at the ceiling
    pending_words.push_back(word_of(FUNC_TICK, 16'd100, 1'b0, KEY_INC, KEY_INC,
                                    1'b0, 1'b0, 16'd0));
    drain();

    // random phases: sender light / receiver heavy idling, then swapped,
    // then back-to-back; each phase on its own register setting
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 24 : (p < 4) ? 70 : 0;
      recv_idle_pct = (p < 2) ? 70 : (p < 4) ? 24 : 0;
      load_setting(plan[p]);
      for (int n = 0; n < WORDS_PER_PHASE; n++) pending_words.push_back(random_word());
      if (p == 4) begin
        // receiver goes quiet mid-phase while the sender keeps pushing
        while (pending_words.size() > WORDS_PER_PHASE / 2) @(posedge clk);
        stall_request = LONG_STALL;
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** drying_rack_motor_dryer_controller: PASSED **");
    end else begin
      $display("** drying_rack_motor_dryer_controller: FAILED **");
    end
    $finish;
  end

endmodule

### drying_rack_motor_dryer_controller.f
hw/rtl/drmc_pkg.sv
hw/rtl/drmc_cfg.sv
hw/rtl/drmc_key.sv
hw/rtl/drmc_step.sv
hw/rtl/drying_rack_motor_dryer_controller.sv
dv/testbench.sv
